>>> rtl/tun_pkg.sv
// package with shared constants and types for the triangle unit normal block
`timescale 1ns / 1ps
package tun_pkg;

    // default widths
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // normalized magnitude width, largest component lies in [2^29, 2^30)
    localparam int TARGET_BITS = 30;
    // sum of three squares and its integer root
    localparam int SQ_XW       = 2 * TARGET_BITS + 2;
    localparam int SQ_RB       = TARGET_BITS + 1;
    localparam int SQ_REMW     = SQ_RB + 1;
    localparam int SQ_STEPS    = SQ_XW / 2;

    // per-item flags carried down the chains
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } side_t;

endpackage

>>> rtl/tun_in_if.sv
// input channel carrying the three triangle vertices
`timescale 1ns / 1ps
interface tun_in_if #(
    parameter int CoordWidth = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [CoordWidth-1:0] ax;
    logic signed [CoordWidth-1:0] ay;
    logic signed [CoordWidth-1:0] az;
    logic signed [CoordWidth-1:0] bx;
    logic signed [CoordWidth-1:0] by_coord;
    logic signed [CoordWidth-1:0] bz;
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic signed [CoordWidth-1:0] cz;

    modport source (
        output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
        input  ready
    );
    modport sink (
        input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
        output ready
    );
endinterface

>>> rtl/tun_out_if.sv
// output channel carrying the unit normal and the degenerate flag
`timescale 1ns / 1ps
interface tun_out_if #(
    parameter int NormBits = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [NormBits-1:0] norm_x;
    logic signed [NormBits-1:0] norm_y;
    logic signed [NormBits-1:0] norm_z;
    logic                       degenerate;

    modport source (
        output valid, norm_x, norm_y, norm_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, norm_x, norm_y, norm_z, degenerate,
        output ready
    );
endinterface

>>> rtl/tun_norm_cell.sv
// one step of the block normalizing shift: shifts all three magnitudes by a fixed amount
`timescale 1ns / 1ps
module tun_norm_cell #(
    parameter int Width = 35,
    parameter int Shift = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vld_in,
    input  tun_pkg::side_t          side_in,
    input  logic [2:0][Width-1:0]   mag_in,
    output logic                    vld_out,
    output tun_pkg::side_t          side_out,
    output logic [2:0][Width-1:0]   mag_out
);
    import tun_pkg::*;

    logic [Width-1:0]       or_all;
    logic                   top_zero;
    logic [2:0][Width-1:0]  mag_next;

    // shift when the top bits of every magnitude are clear
    always_comb
    begin
        or_all   = mag_in[0] | mag_in[1] | mag_in[2];
        top_zero = ~|or_all[Width-1 -: Shift];
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = top_zero ? (mag_in[i] << Shift) : mag_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out <= 1'b0;
        end
        else if (en)
        begin
            vld_out <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side_in;
            mag_out  <= mag_next;
        end
    end
endmodule

>>> rtl/tun_sqrt_cell.sv
// one digit step of the integer square root, carrying the normalized magnitudes along
`timescale 1ns / 1ps
module tun_sqrt_cell (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      vld_in,
    input  tun_pkg::side_t                            side_in,
    input  logic [2:0][tun_pkg::TARGET_BITS-1:0]      m_in,
    input  logic [tun_pkg::SQ_XW-1:0]                 x_in,
    input  logic [tun_pkg::SQ_REMW-1:0]               rem_in,
    input  logic [tun_pkg::SQ_RB-1:0]                 root_in,
    output logic                                      vld_out,
    output tun_pkg::side_t                            side_out,
    output logic [2:0][tun_pkg::TARGET_BITS-1:0]      m_out,
    output logic [tun_pkg::SQ_XW-1:0]                 x_out,
    output logic [tun_pkg::SQ_REMW-1:0]               rem_out,
    output logic [tun_pkg::SQ_RB-1:0]                 root_out
);
    import tun_pkg::*;

    logic [SQ_REMW+1:0] rem_sh;
    logic [SQ_REMW+1:0] trial;
    logic               ge;
    logic [SQ_REMW+1:0] rem_sub;

    // bring down two bits, try 4*root+1
    always_comb
    begin
        rem_sh  = {rem_in, x_in[SQ_XW-1 -: 2]};
        trial   = (SQ_REMW+2)'({root_in, 2'b01});
        ge      = (rem_sh >= trial);
        rem_sub = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out <= 1'b0;
        end
        else if (en)
        begin
            vld_out <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side_in;
            m_out    <= m_in;
            x_out    <= x_in << 2;
            rem_out  <= rem_sub[SQ_REMW-1:0];
            root_out <= {root_in[SQ_RB-2:0], ge};
        end
    end
endmodule

>>> rtl/tun_div_cell.sv
// one quotient bit of the restoring divide, three lanes sharing one divisor
`timescale 1ns / 1ps
module tun_div_cell #(
    parameter int FracBits = 14,
    parameter int Bit      = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          vld_in,
    input  tun_pkg::side_t                                side_in,
    input  logic [tun_pkg::SQ_RB-1:0]                     l_in,
    input  logic [2:0][tun_pkg::TARGET_BITS+FracBits:0]   rem_in,
    input  logic [2:0][FracBits:0]                        q_in,
    output logic                                          vld_out,
    output tun_pkg::side_t                                side_out,
    output logic [tun_pkg::SQ_RB-1:0]                     l_out,
    output logic [2:0][tun_pkg::TARGET_BITS+FracBits:0]   rem_out,
    output logic [2:0][FracBits:0]                        q_out
);
    import tun_pkg::*;

    localparam int DW = TARGET_BITS + FracBits + 1;

    logic [DW-1:0]        dvs;
    logic [2:0]           ge;
    logic [2:0][DW-1:0]   rem_next;
    logic [2:0][FracBits:0] q_next;

    // compare against the divisor at this bit weight
    always_comb
    begin
        dvs = DW'(l_in) << Bit;
        for (int i = 0; i < 3; i++)
        begin
            ge[i]       = (rem_in[i] >= dvs);
            rem_next[i] = ge[i] ? (rem_in[i] - dvs) : rem_in[i];
            q_next[i]   = {q_in[i][FracBits-1:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out <= 1'b0;
        end
        else if (en)
        begin
            vld_out <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side_in;
            l_out    <= l_in;
            rem_out  <= rem_next;
            q_out    <= q_next;
        end
    end
endmodule

>>> rtl/triangle_unit_normal.sv
// top level of the triangle unit normal block
//
// in_ch carries one triangle per item (nine signed coordinates); out_ch returns
// one item per triangle: the unit normal in signed Q1.F form plus a degenerate
// flag, given with zero normals when the cross product is zero.
// Both channels use valid/ready; an item moves on a clock edge where both are high.
// Throughput: one triangle per cycle, every cycle, while the receiver keeps up.
// Items pass through the edge, product and cross product stages, the chain of
// normalize cells, the squares, the 31 root cells and the divide cells on to
// out_ch; each root and divide cell yields one result bit.
// The output register is backed by a one-item skid register; in_ch.ready comes
// from a flop and drops only once the skid holds an item, then the whole chain
// holds until the receiver takes items again.
// Reset clears all valid flags; no item is in flight after reset.
`timescale 1ns / 1ps
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tun_in_if.sink     in_ch,
    tun_out_if.source  out_ch
);
    import tun_pkg::*;

    localparam int E   = COORD_WIDTH + 1;
    localparam int PW  = 2 * COORD_WIDTH + 2;
    localparam int MW  = 2 * COORD_WIDTH + 1;
    localparam int NW  = (MW > TARGET_BITS) ? MW : TARGET_BITS;
    localparam int KS  = $clog2(NW);
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int QB  = F + 1;
    localparam int OB  = F + 2;
    localparam int DW  = TARGET_BITS + F + 1;

    logic en;

    // stage 1: edges
    logic                v1_reg;
    logic signed [E-1:0] u_reg [3];
    logic signed [E-1:0] v_reg [3];

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [6];

    // stage 3: cross product components
    logic                 v3_reg;
    logic signed [PW-1:0] n_reg [3];

    // normalize chain
    logic [KS:0]           nv;
    side_t                 nside [KS+1];
    logic [2:0][NW-1:0]    nmag  [KS+1];

    // squares and their sum
    logic                              v5_reg;
    side_t                             side5_reg;
    logic [2:0][TARGET_BITS-1:0]       m5_reg;
    logic [2:0][2*TARGET_BITS-1:0]     sq5_reg;
    logic                              v6_reg;
    side_t                             side6_reg;
    logic [2:0][TARGET_BITS-1:0]       m6_reg;
    logic [SQ_XW-1:0]                  s6_reg;

    // root chain
    logic [SQ_STEPS:0]                 sv;
    side_t                             sside [SQ_STEPS+1];
    logic [2:0][TARGET_BITS-1:0]       sm    [SQ_STEPS+1];
    logic [SQ_XW-1:0]                  sx    [SQ_STEPS+1];
    logic [SQ_REMW-1:0]                srem  [SQ_STEPS+1];
    logic [SQ_RB-1:0]                  sroot [SQ_STEPS+1];

    // divide chain
    logic [QB:0]                       dv;
    side_t                             dside [QB+1];
    logic [SQ_RB-1:0]                  dl    [QB+1];
    logic [2:0][DW-1:0]                drem  [QB+1];
    logic [2:0][QB-1:0]                dq    [QB+1];

    // final result and output buffering
    logic                   res_vld;
    logic signed [OB-1:0]   res_norm [3];
    logic                   res_degen;
    logic                   out_valid_reg;
    logic signed [OB-1:0]   out_norm_reg [3];
    logic                   out_degen_reg;
    logic                   skid_valid_reg;
    logic signed [OB-1:0]   skid_norm_reg [3];
    logic                   skid_degen_reg;

    assign en          = ~skid_valid_reg;
    assign in_ch.ready = en;

    // valid flags of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            nv[0]  <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            sv[0]  <= 1'b0;
            dv[0]  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            nv[0]  <= v3_reg;
            v5_reg <= nv[KS];
            v6_reg <= v5_reg;
            sv[0]  <= v6_reg;
            dv[0]  <= sv[SQ_STEPS];
        end
    end

    // edges, products, cross product and magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0] <= $signed({in_ch.bx[COORD_WIDTH-1], in_ch.bx})
                      - $signed({in_ch.ax[COORD_WIDTH-1], in_ch.ax});
            u_reg[1] <= $signed({in_ch.by_coord[COORD_WIDTH-1], in_ch.by_coord})
                      - $signed({in_ch.ay[COORD_WIDTH-1], in_ch.ay});
            u_reg[2] <= $signed({in_ch.bz[COORD_WIDTH-1], in_ch.bz})
                      - $signed({in_ch.az[COORD_WIDTH-1], in_ch.az});
            v_reg[0] <= $signed({in_ch.cx[COORD_WIDTH-1], in_ch.cx})
                      - $signed({in_ch.ax[COORD_WIDTH-1], in_ch.ax});
            v_reg[1] <= $signed({in_ch.cy[COORD_WIDTH-1], in_ch.cy})
                      - $signed({in_ch.ay[COORD_WIDTH-1], in_ch.ay});
            v_reg[2] <= $signed({in_ch.cz[COORD_WIDTH-1], in_ch.cz})
                      - $signed({in_ch.az[COORD_WIDTH-1], in_ch.az});

            p_reg[0] <= u_reg[1] * v_reg[2];
            p_reg[1] <= u_reg[2] * v_reg[1];
            p_reg[2] <= u_reg[2] * v_reg[0];
            p_reg[3] <= u_reg[0] * v_reg[2];
            p_reg[4] <= u_reg[0] * v_reg[1];
            p_reg[5] <= u_reg[1] * v_reg[0];

            n_reg[0] <= p_reg[0] - p_reg[1];
            n_reg[1] <= p_reg[2] - p_reg[3];
            n_reg[2] <= p_reg[4] - p_reg[5];

            nside[0].degen <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
            for (int i = 0; i < 3; i++)
            begin
                nside[0].neg[i] <= n_reg[i][PW-1];
                nmag[0][i]      <= NW'(MW'(n_reg[i][PW-1] ? -n_reg[i] : n_reg[i]));
            end
        end
    end

    // block normalizing shift, one power of two per cell
    for (genvar k = 0; k < KS; k++)
    begin : g_norm
        tun_norm_cell #(
            .Width (NW),
            .Shift (1 << (KS - 1 - k))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (nv[k]),
            .side_in  (nside[k]),
            .mag_in   (nmag[k]),
            .vld_out  (nv[k+1]),
            .side_out (nside[k+1]),
            .mag_out  (nmag[k+1])
        );
    end

    // squares of the normalized magnitudes, then their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side5_reg <= nside[KS];
            for (int i = 0; i < 3; i++)
            begin
                m5_reg[i]  <= nmag[KS][i][NW-1 -: TARGET_BITS];
                sq5_reg[i] <= nmag[KS][i][NW-1 -: TARGET_BITS]
                            * nmag[KS][i][NW-1 -: TARGET_BITS];
            end
            side6_reg <= side5_reg;
            m6_reg    <= m5_reg;
            s6_reg    <= SQ_XW'(sq5_reg[0]) + SQ_XW'(sq5_reg[1]) + SQ_XW'(sq5_reg[2]);
        end
    end

    // seed of the root chain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sside[0] <= side6_reg;
            sm[0]    <= m6_reg;
            sx[0]    <= s6_reg;
            srem[0]  <= '0;
            sroot[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        tun_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sv[j]),
            .side_in  (sside[j]),
            .m_in     (sm[j]),
            .x_in     (sx[j]),
            .rem_in   (srem[j]),
            .root_in  (sroot[j]),
            .vld_out  (sv[j+1]),
            .side_out (sside[j+1]),
            .m_out    (sm[j+1]),
            .x_out    (sx[j+1]),
            .rem_out  (srem[j+1]),
            .root_out (sroot[j+1])
        );
    end

    // dividends with half the divisor added for rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside[0] <= sside[SQ_STEPS];
            dl[0]    <= sroot[SQ_STEPS];
            dq[0]    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                drem[0][i] <= (DW'(sm[SQ_STEPS][i]) << F)
                            + DW'(sroot[SQ_STEPS] >> 1);
            end
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        tun_div_cell #(
            .FracBits (F),
            .Bit      (F - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (dv[j]),
            .side_in  (dside[j]),
            .l_in     (dl[j]),
            .rem_in   (drem[j]),
            .q_in     (dq[j]),
            .vld_out  (dv[j+1]),
            .side_out (dside[j+1]),
            .l_out    (dl[j+1]),
            .rem_out  (drem[j+1]),
            .q_out    (dq[j+1])
        );
    end

    // apply signs, force zeros for a degenerate triangle
    always_comb
    begin
        res_vld   = en && dv[QB];
        res_degen = dside[QB].degen;
        for (int i = 0; i < 3; i++)
        begin
            if (dside[QB].degen)
            begin
                res_norm[i] = '0;
            end
            else if (dside[QB].neg[i])
            begin
                res_norm[i] = -$signed(OB'(dq[QB][i]));
            end
            else
            begin
                res_norm[i] = $signed(OB'(dq[QB][i]));
            end
        end
    end

    // output register and skid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ch.ready)
        begin
            if (res_vld)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= res_vld;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ch.ready)
        begin
            if (res_vld)
            begin
                skid_norm_reg  <= res_norm;
                skid_degen_reg <= res_degen;
            end
        end
        else if (skid_valid_reg)
        begin
            out_norm_reg  <= skid_norm_reg;
            out_degen_reg <= skid_degen_reg;
        end
        else
        begin
            out_norm_reg  <= res_norm;
            out_degen_reg <= res_degen;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.norm_x     = out_norm_reg[0];
    assign out_ch.norm_y     = out_norm_reg[1];
    assign out_ch.norm_z     = out_norm_reg[2];
    assign out_ch.degenerate = out_degen_reg;

    // the skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    // the skid register fills only when the receiver stalled a waiting item
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ch.ready))
        else $error("skid register filled without a stall");

    // a degenerate item carries zero normals
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.degenerate) |->
            (out_ch.norm_x == '0 && out_ch.norm_y == '0 && out_ch.norm_z == '0))
        else $error("degenerate item with nonzero normal");

    // unit normal components never exceed one
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            (out_ch.norm_x <= $signed(OB'(1 << F)) && out_ch.norm_x >= -$signed(OB'(1 << F))
          && out_ch.norm_y <= $signed(OB'(1 << F)) && out_ch.norm_y >= -$signed(OB'(1 << F))
          && out_ch.norm_z <= $signed(OB'(1 << F)) && out_ch.norm_z >= -$signed(OB'(1 << F))))
        else $error("normal component out of range");
endmodule
